>>> design/cirfb_pkg.sv
// Shared types and constants for the circle rasterizer framebuffer.
// No dependencies; imported by the top level.
package cirfb_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 64;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 12;
  localparam int RAD_W  = 11;
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 7;

  // Internal widths: coordinates/offsets and error terms
  localparam int CW = 14;
  localparam int EW = 16;

  // Config register indexes
  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CIRCLE = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX,
    S_RD_ADDR,
    S_RD_DATA,
    S_POINT,
    S_UPD_Y,
    S_UPD_X,
    S_RESP
  } state_e;

endpackage

>>> design/cirfb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module cirfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/circle_rasterizer_framebuffer.sv
// Top level of the circle rasterizer framebuffer: command sequencer,
// shared clip/address unit and octant walker. Uses cirfb_pkg and cirfb_ram.
//
// One command is taken at a time; in_stall_o is high while a command is in
// work, and a finished result may wait in the output register while the next
// command is taken. A write pixel passes S_PIX and S_RESP, a read pixel S_PIX,
// S_RD_ADDR, S_RD_DATA and S_RESP. Each octant step of a circle sends eight
// points through the clip and address unit, one point per cycle into the single
// write port of the frame memory, then updates the error terms in S_UPD_Y and
// S_UPD_X. Radius zero and the unused command go straight to S_RESP. After
// reset all MAX_ROWS * MAX_COLUMNS frame memory entries are cleared, one entry a
// cycle, with input stalled; configuration writes are taken throughout.
module circle_rasterizer_framebuffer
  import cirfb_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic [RAD_W-1:0]        radius_i,
  input  logic [PIX_W-1:0]        pixel_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PIX_W-1:0]        read_value_o
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] row_count_q, column_count_q;

  cmd_e                    cmd_q, cmd_d;
  logic signed [POS_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [PIX_W-1:0]        val_q, val_d;
  logic signed [CW-1:0]    x_q, x_d, y_q, y_d, dy_q, dy_d;
  logic signed [EW-1:0]    err_q, err_d, k_q, k_d;
  logic [2:0]              pt_q, pt_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic                    ok_q, ok_d;
  logic [PIX_W-1:0]        res_q, res_d;

  logic                    mem_we_q, mem_we_d;
  logic [AW-1:0]           mem_addr_q, mem_addr_d;
  logic [PIX_W-1:0]        mem_wdata_q, mem_wdata_d;
  logic [PIX_W-1:0]        mem_rdata;

  logic                    out_valid_q, out_valid_d;
  logic [PIX_W-1:0]        read_value_q, read_value_d;

  // Active area, clamped to the memory dimensions
  logic [CW-1:0] rc_ext, cc_ext, r_act, c_act;
  assign rc_ext = CW'(row_count_q);
  assign cc_ext = CW'(column_count_q);
  assign r_act  = (rc_ext > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : rc_ext;
  assign c_act  = (cc_ext > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : cc_ext;

  // Shared point unit: offset select, clip and linear address
  logic                 swap, neg_a, neg_b, use_off;
  logic signed [CW-1:0] off_a, off_b, cx_ext, cy_ext, ax, ay;
  logic                 in_area;
  logic [2*CW-1:0]      lin;

  always_comb begin
    swap  = (pt_q == 3'd1) || (pt_q == 3'd2) || (pt_q == 3'd5) || (pt_q == 3'd6);
    neg_a = (pt_q >= 3'd2) && (pt_q <= 3'd5);
    neg_b = pt_q[2];
    use_off = (state_q == S_POINT);
    off_a = swap ? y_q : x_q;
    off_b = swap ? x_q : y_q;
    if (neg_a) begin
      off_a = -off_a;
    end
    if (neg_b) begin
      off_b = -off_b;
    end
    if (!use_off) begin
      off_a = '0;
      off_b = '0;
    end
    cx_ext = {{(CW-POS_W){cx_q[POS_W-1]}}, cx_q};
    cy_ext = {{(CW-POS_W){cy_q[POS_W-1]}}, cy_q};
    ax = cx_ext + off_a;
    ay = cy_ext + off_b;
    in_area = !ax[CW-1] && ($unsigned(ax) < r_act) &&
              !ay[CW-1] && ($unsigned(ay) < c_act);
    lin = (2*CW)'($unsigned(ax)) * (2*CW)'(c_act) + (2*CW)'($unsigned(ay));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CFG_W'(64);
      column_count_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    val_d        = val_q;
    x_d          = x_q;
    y_d          = y_q;
    dy_d         = dy_q;
    err_d        = err_q;
    k_d          = k_q;
    pt_d         = pt_q;
    clr_d        = clr_q;
    ok_d         = ok_q;
    res_d        = res_q;
    mem_we_d     = 1'b0;
    mem_addr_d   = mem_addr_q;
    mem_wdata_d  = mem_wdata_q;
    out_valid_d  = out_valid_q && out_stall_i;
    read_value_d = read_value_q;

    case (state_q)
      S_CLEAR: begin
        mem_we_d    = 1'b1;
        mem_addr_d  = clr_q;
        mem_wdata_d = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_e'(command_i);
          cx_d  = pos_x_i;
          cy_d  = pos_y_i;
          val_d = pixel_value_i;
          res_d = '0;
          pt_d  = '0;
          x_d   = {{(CW-RAD_W){1'b0}}, radius_i} - CW'(1);
          y_d   = '0;
          dy_d  = CW'(1);
          err_d = EW'(1) - {{(EW-RAD_W-1){1'b0}}, radius_i, 1'b0};
          k_d   = EW'(1) - {{(EW-RAD_W-1){1'b0}}, radius_i, 1'b0};
          case (cmd_e'(command_i))
            CMD_WRITE, CMD_READ: state_d = S_PIX;
            CMD_CIRCLE: state_d = (radius_i == '0) ? S_RESP : S_POINT;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_PIX: begin
        mem_addr_d = lin[AW-1:0];
        ok_d       = in_area;
        if (cmd_q == CMD_WRITE) begin
          mem_we_d    = in_area;
          mem_wdata_d = val_q;
          state_d     = S_RESP;
        end else begin
          state_d = S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_d   = ok_q ? mem_rdata : '0;
        state_d = S_RESP;
      end
      S_POINT: begin
        mem_we_d    = in_area;
        mem_addr_d  = lin[AW-1:0];
        mem_wdata_d = PIX_W'(1);
        pt_d        = pt_q + 3'd1;
        if (pt_q == 3'd7) begin
          state_d = S_UPD_Y;
        end
      end
      S_UPD_Y: begin
        if (err_q[EW-1] || (err_q == '0)) begin
          y_d   = y_q + CW'(1);
          err_d = err_q + EW'(dy_q);
          dy_d  = dy_q + CW'(2);
        end
        state_d = S_UPD_X;
      end
      S_UPD_X: begin
        if (!err_q[EW-1] && (err_q != '0)) begin
          x_d   = x_q - CW'(1);
          k_d   = k_q + EW'(2);
          err_d = err_q + k_q + EW'(2);
        end
        state_d = (x_d >= y_q) ? S_POINT : S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          read_value_d = res_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pt_q        <= '0;
      mem_we_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pt_q        <= pt_d;
      mem_we_q    <= mem_we_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    cx_q         <= cx_d;
    cy_q         <= cy_d;
    val_q        <= val_d;
    x_q          <= x_d;
    y_q          <= y_d;
    dy_q         <= dy_d;
    err_q        <= err_d;
    k_q          <= k_d;
    ok_q         <= ok_d;
    res_q        <= res_d;
    mem_addr_q   <= mem_addr_d;
    mem_wdata_q  <= mem_wdata_d;
    read_value_q <= read_value_d;
  end

  cirfb_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we_q),
    .addr_i (mem_addr_q),
    .wdata_i(mem_wdata_q),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

`ifndef SYNTHESIS
  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_ADDR) |-> !mem_we_q)
    else $error("frame memory written during a pixel read");

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (mem_we_q && (mem_wdata_q == '0)))
    else $error("clearing pass missed a zero write");

  a_point_in_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POINT) |-> (y_q <= x_q))
    else $error("octant walk past its end");

  a_clipped_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RD_DATA) && !ok_q) |=> (res_q == '0))
    else $error("clipped read returned nonzero");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(read_value_q))
    else $error("waiting result overwritten");
`endif

endmodule

>>> dv/circle_rasterizer_framebuffer_test.sv
// Self-checking testbench for circle_rasterizer_framebuffer: drives pixel and circle
// commands, predicts the read_value of every beat and checks it. Depends on cirfb_pkg.
`timescale 1ns / 100ps

module circle_rasterizer_framebuffer_test
  import cirfb_pkg::*;
();

  localparam int CLK_PERIOD = 8;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_BEAT = 250;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  class framebuffer_scoreboard;
    logic [PIX_W-1:0] pixels [MAX_ROWS_DEF*MAX_COLUMNS_DEF];
    logic [CFG_W-1:0] rows, cols;
    logic [PIX_W-1:0] read_values_due [$];
    int errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      rows = CFG_RESET;
      cols = CFG_RESET;
      errors = 0;
    endfunction

    function void write_config(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_ROW_COUNT) rows = data;
      else cols = data;
    endfunction

    function int span(logic [CFG_W-1:0] n, int lim);
      return (int'(n) > lim) ? lim : int'(n);
    endfunction

    function bit locate(int x, int y, output int a);
      int r, c;
      r = span(rows, MAX_ROWS_DEF);
      c = span(cols, MAX_COLUMNS_DEF);
      a = 0;
      if (x < 0 || x >= r || y < 0 || y >= c) return 1'b0;
      a = x * c + y;
      return 1'b1;
    endfunction

    function void plot(int x, int y, logic [PIX_W-1:0] v);
      int a;
      if (locate(x, y, a)) pixels[a] = v;
    endfunction

    function void trace_circle(int cx, int cy, int r);
      int x, y, dx, dy, err_term;
      x = r - 1;
      y = 0;
      dx = 1;
      dy = 1;
      err_term = dx - 2 * r;
      while (x >= y) begin
        plot(cx + x, cy + y, 8'd1);
        plot(cx + y, cy + x, 8'd1);
        plot(cx - y, cy + x, 8'd1);
        plot(cx - x, cy + y, 8'd1);
        plot(cx - x, cy - y, 8'd1);
        plot(cx - y, cy - x, 8'd1);
        plot(cx + y, cy - x, 8'd1);
        plot(cx + x, cy - y, 8'd1);
        if (err_term <= 0) begin
          y++;
          err_term += dy;
          dy += 2;
        end
        if (err_term > 0) begin
          x--;
          dx += 2;
          err_term += dx - 2 * r;
        end
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [POS_W-1:0] px,
                               logic signed [POS_W-1:0] py, logic [RAD_W-1:0] rad,
                               logic [PIX_W-1:0] val);
      int a;
      logic [PIX_W-1:0] rd;
      rd = '0;
      if (cmd == CMD_WRITE) begin
        plot(px, py, val);
      end else if (cmd == CMD_READ) begin
        if (locate(px, py, a)) rd = pixels[a];
      end else if (cmd == CMD_CIRCLE) begin
        trace_circle(px, py, int'(rad));
      end
      read_values_due.push_back(rd);
    endfunction

    function void check_read_value(logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      if (read_values_due.size() == 0) begin
        $error("read_value: expected no beat, got %0d", got);
        errors++;
        return;
      end
      want = read_values_due.pop_front();
      if (got !== want) begin
        $error("read_value: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return read_values_due.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        command_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic [RAD_W-1:0]        radius_i;
  logic [PIX_W-1:0]        pixel_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [PIX_W-1:0]        read_value_o;

  framebuffer_scoreboard sb;
  bit quiet;
  int idle_cycles = 0;
  int recent_x [$];
  int recent_y [$];

  circle_rasterizer_framebuffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .radius_i      (radius_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int draw_idle();
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic signed [POS_W-1:0] pick_coord(int extent);
    int v;
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
    v = int'($urandom_range(0, extent + 7)) - 4;
    return v[POS_W-1:0];
  endfunction

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.write_config(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Entered and left at a falling edge.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [POS_W-1:0] px,
                           logic signed [POS_W-1:0] py, logic [RAD_W-1:0] rad,
                           logic [PIX_W-1:0] val);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    pos_x_i = px;
    pos_y_i = py;
    radius_i = rad;
    pixel_value_i = val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, px, py, rad, val);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic random_item();
    logic [CMD_W-1:0] cmd;
    logic signed [POS_W-1:0] px, py;
    logic [RAD_W-1:0] rad;
    int roll, k;
    roll = $urandom_range(0, 99);
    cmd = (roll < 36) ? CMD_WRITE : (roll < 70) ? CMD_READ :
          (roll < 95) ? CMD_CIRCLE : CMD_UNUSED;
    px = pick_coord(sb.span(sb.rows, MAX_ROWS_DEF));
    py = pick_coord(sb.span(sb.cols, MAX_COLUMNS_DEF));
    roll = $urandom_range(0, 39);
    if (roll == 0) rad = RAD_W'($urandom);
    else if (roll < 8) rad = RAD_W'($urandom_range(0, 3));
    else rad = RAD_W'($urandom_range(0, 40));
    if (cmd == CMD_READ && recent_x.size() > 0 && $urandom_range(0, 1) == 1) begin
      k = $urandom_range(0, recent_x.size() - 1);
      px = POS_W'(recent_x[k]);
      py = POS_W'(recent_y[k]);
    end
    if (cmd == CMD_WRITE) begin
      recent_x.push_back(px);
      recent_y.push_back(py);
      if (recent_x.size() > 16) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
      end
    end
    send_item(cmd, px, py, rad, PIX_W'($urandom));
  endtask

  task automatic run_phase(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols, bit calm);
    drain();
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COLUMN_COUNT, cols);
    quiet = calm;
    repeat (PHASE_ITEMS) random_item();
  endtask

  // Result side: draws a hold per beat, plus one long hold to back up the block.
  initial begin
    int hold;
    int beats_seen;
    beats_seen = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = (beats_seen == HOLD_AT_BEAT) ? LONG_HOLD : draw_idle();
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_read_value(read_value_o);
      beats_seen++;
    end
  end

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ROW_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_WRITE;
    pos_x_i = '0;
    pos_y_i = '0;
    radius_i = '0;
    pixel_value_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_ROW_COUNT, CFG_RESET);
    write_reg(CFG_COLUMN_COUNT, CFG_RESET);

    // corners, clipping on both sides, all command kinds
    send_item(CMD_WRITE, 0, 0, 0, 8'hFF);
    send_item(CMD_WRITE, 63, 63, 0, 8'hAA);
    send_item(CMD_WRITE, 63, 0, 0, 8'h55);
    send_item(CMD_WRITE, 0, 63, 0, 8'h5A);
    send_item(CMD_WRITE, -1, 5, 0, 8'h07);
    send_item(CMD_WRITE, 5, 64, 0, 8'h09);
    send_item(CMD_WRITE, -2048, 2047, 11'h7FF, 8'h80);
    send_item(CMD_READ, 0, 0, 0, 0);
    send_item(CMD_READ, 63, 63, 0, 0);
    send_item(CMD_READ, -1, 5, 0, 0);
    send_item(CMD_READ, 2047, -2048, 0, 8'hFF);
    send_item(CMD_READ, 0, 63, 0, 0);
    // zero radius draws nothing, radius one only the center
    send_item(CMD_CIRCLE, 10, 9, 0, 0);
    send_item(CMD_READ, 10, 9, 0, 0);
    send_item(CMD_CIRCLE, 20, 20, 1, 0);
    send_item(CMD_READ, 20, 20, 0, 0);
    send_item(CMD_CIRCLE, 32, 32, 5, 0);
    send_item(CMD_READ, 36, 32, 0, 0);
    send_item(CMD_CIRCLE, 30, 30, 40, 8'hFF);
    send_item(CMD_READ, 63, 30, 0, 0);
    send_item(CMD_CIRCLE, -2048, 2047, 11'h7FF, 0);
    send_item(CMD_UNUSED, 3, 3, 11'h155, 8'hC3);
    send_item(CMD_READ, 63, 0, 0, 0);
    send_item(CMD_READ, 3, 3, 0, 0);

    quiet = 1'b0;
    repeat (PHASE_ITEMS) random_item();
    run_phase(7'd127, 7'd127, 1'b0);
    run_phase(7'd0, 7'd37, 1'b1);
    run_phase(7'd1, 7'd1, 1'b0);
    run_phase(7'd64, 7'd1, 1'b0);
    run_phase(7'd1, 7'd64, 1'b1);
    run_phase(7'd65, 7'd0, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 127)), CFG_W'($urandom_range(1, 127)), 1'b0);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)), 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/cirfb_pkg.sv
design/cirfb_ram.sv
design/circle_rasterizer_framebuffer.sv
dv/circle_rasterizer_framebuffer_test.sv
